/* rtl/gpsdf_pkg.sv */
`default_nettype none

package gpsdf_pkg;

  // Command codes carried on the request
  localparam int CMD_W = 3;
  typedef enum logic [CMD_W-1:0] {
    CMD_SET_POINT   = 3'd0,
    CMD_ERASE_POINT = 3'd1,
    CMD_FILL_DISC   = 3'd2,
    CMD_CLEAR_DISC  = 3'd3,
    CMD_PICK_FIRST  = 3'd4
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam int GRID_W = 7;
  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

  localparam int DEFAULT_MAX_COLUMNS = 64;
  localparam int DEFAULT_MAX_ROWS    = 64;

  // Effective grid sizes: covers the 7-bit registers and the largest grid (256)
  localparam int SIZE_W = 9;

  localparam int COORD_W  = 13;  // signed point / centre coordinate
  localparam int RADIUS_W = 12;
  localparam int PICK_W   = 6;   // picked_x / picked_y

  // Disc arithmetic
  localparam int DY_W   = COORD_W + 1;   // row minus centre row
  localparam int SQ_W   = 25;            // dy squared, largest row offset 4351
  localparam int R2_W   = 2 * RADIUS_W;  // radius squared
  localparam int ROOT_W = RADIUS_W;      // integer square root of a value up to r^2
  localparam int SPAN_W = COORD_W + 2;   // centre plus or minus root

  // Square root unit: bits of root resolved per cycle
  localparam int ROOT_STEPS  = 4;
  localparam int ROOT_CYCLES = ROOT_W / ROOT_STEPS;
  localparam int ROOT_CNT_W  = 2;

endpackage

`default_nettype wire

/* rtl/gpsdf_row_ram.sv */
`default_nettype none

module gpsdf_row_ram #(
  parameter int DEPTH = gpsdf_pkg::DEFAULT_MAX_ROWS,
  parameter int WIDTH = gpsdf_pkg::DEFAULT_MAX_COLUMNS
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  import gpsdf_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/gpsdf_isqrt.sv */
`default_nettype none

module gpsdf_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gpsdf_pkg::R2_W-1:0]  value,
  output logic                        done,
  output logic [gpsdf_pkg::ROOT_W-1:0] root
);
  import gpsdf_pkg::*;

  logic [R2_W-1:0]       rad;
  logic [ROOT_W+1:0]     rem;
  logic [ROOT_CNT_W-1:0] cnt;

  logic [R2_W-1:0]   rad_next;
  logic [ROOT_W+1:0] rem_next;
  logic [ROOT_W-1:0] root_next;

  // Restoring square root, two radicand bits per root bit
  always_comb begin
    logic [ROOT_W+3:0] t;
    logic [ROOT_W+3:0] trial;
    rad_next  = rad;
    rem_next  = rem;
    root_next = root;
    for (int s = 0; s < ROOT_STEPS; s++) begin
      t     = {rem_next, rad_next[R2_W-1 -: 2]};
      trial = {2'b00, root_next, 2'b01};
      rad_next = {rad_next[R2_W-3:0], 2'b00};
      if (t >= trial) begin
        rem_next  = (ROOT_W+2)'(t - trial);
        root_next = {root_next[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = t[ROOT_W+1:0];
        root_next = {root_next[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= ROOT_CNT_W'(ROOT_CYCLES);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == ROOT_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= value;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= rad_next;
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/grid_point_set_with_disc_fill.sv */
// Unknown, out-of-grid and empty-grid requests answer in the cycle after acceptance. Point set
// and erase read the row, then write it back; pick first walks the row marks to the first
// occupied one, then clears its lowest bit; a disc squares and tests every grid row and, in
// the band, waits for the square root and writes the row back. One request at a time, set by
// the per-row read-modify-write and the square root unit. The receiver cannot stall: each
// result shows for one cycle on done. Reset clears the row marks and sets the grid to 64x64.
`default_nettype none

module grid_point_set_with_disc_fill #(
  parameter int MAX_COLUMNS = gpsdf_pkg::DEFAULT_MAX_COLUMNS,
  parameter int MAX_ROWS    = gpsdf_pkg::DEFAULT_MAX_ROWS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // request channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic [gpsdf_pkg::CMD_W-1:0]            command,
  input  logic signed [gpsdf_pkg::COORD_W-1:0]   point_x,
  input  logic signed [gpsdf_pkg::COORD_W-1:0]   point_y,
  input  logic [gpsdf_pkg::RADIUS_W-1:0]         radius,
  // configuration channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gpsdf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [gpsdf_pkg::GRID_W-1:0]           cfg_data,
  // result strobe
  output logic                                   done,
  output logic [gpsdf_pkg::PICK_W-1:0]           picked_x,
  output logic [gpsdf_pkg::PICK_W-1:0]           picked_y,
  output logic                                   set_was_empty
);
  import gpsdf_pkg::*;

  localparam int XW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PT_RD,    // read the addressed row
    ST_PT_WR,    // set or clear one bit, write back
    ST_DK_SQ,    // square the row offset, read the row
    ST_DK_CMP,   // test the row against the disc, start the root
    ST_DK_ROOT,  // wait for the half chord, form the column span
    ST_DK_WR,    // merge the span into the row, write back
    ST_PK_SCAN,  // walk the row marks
    ST_PK_WR     // drop the lowest bit of the found row
  } state_t;

  state_t state;

  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_height;

  // One mark per row: set exactly when the stored row holds a point. An unmarked
  // row reads as empty, so the memory needs no clearing pass after reset.
  logic [MAX_ROWS-1:0] marks;

  logic [YW-1:0]                row;
  logic [XW-1:0]                pt_x;
  logic                         fill;
  logic signed [COORD_W-1:0]    cx;
  logic signed [COORD_W-1:0]    cy;
  logic [R2_W-1:0]              r2;
  logic [SQ_W-1:0]              dy2;
  logic signed [SPAN_W-1:0]     lo;
  logic signed [SPAN_W-1:0]     hi;

  // bitmap memory ports
  logic                   rd_en;
  logic [MAX_COLUMNS-1:0] rd_data;
  logic                   wr_en;
  logic [MAX_COLUMNS-1:0] wr_data;

  // square root unit
  logic              sqrt_start;
  logic [R2_W-1:0]   sqrt_value;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  logic [SIZE_W-1:0]         w_eff;
  logic [SIZE_W-1:0]         h_eff;
  logic [YW-1:0]             last_row;
  logic                      in_grid;
  logic signed [DY_W-1:0]    dy;
  logic signed [2*DY_W-1:0]  dy_prod;
  logic                      band_miss;
  logic [MAX_COLUMNS-1:0]    cur_row;
  logic [MAX_COLUMNS-1:0]    disc_mask;
  logic [MAX_COLUMNS-1:0]    pt_mask;
  logic [MAX_COLUMNS-1:0]    pk_mask;
  logic [XW-1:0]             first_col;
  logic [MAX_COLUMNS-1:0]    new_row;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  // Clamp the configured grid to the built size
  assign w_eff = (SIZE_W'(grid_width) > SIZE_W'(MAX_COLUMNS)) ? SIZE_W'(MAX_COLUMNS)
                                                              : SIZE_W'(grid_width);
  assign h_eff = (SIZE_W'(grid_height) > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS)
                                                            : SIZE_W'(grid_height);
  assign last_row = YW'(h_eff - SIZE_W'(1));

  assign in_grid = !point_x[COORD_W-1] && !point_y[COORD_W-1] &&
                   ({1'b0, point_x[COORD_W-2:0]} < COORD_W'(w_eff)) &&
                   ({1'b0, point_y[COORD_W-2:0]} < COORD_W'(h_eff));

  // Row offset from the disc centre and its square
  assign dy        = $signed(DY_W'(row)) - $signed({cy[COORD_W-1], cy});
  assign dy_prod   = (2*DY_W)'(dy) * (2*DY_W)'(dy);
  assign band_miss = (dy2 > {1'b0, r2});

  assign sqrt_start = (state == ST_DK_CMP) && !band_miss;
  assign sqrt_value = r2 - dy2[R2_W-1:0];

  assign cur_row = marks[row] ? rd_data : '0;

  // Columns inside the clipped span centre +/- root
  always_comb begin
    disc_mask = '0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      disc_mask[i] = ($signed(SPAN_W'(i)) >= lo) && ($signed(SPAN_W'(i)) <= hi) &&
                     (SIZE_W'(i) < w_eff);
    end
  end

  // Lowest occupied column of the row under pick
  always_comb begin
    first_col = '0;
    for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
      if (cur_row[i]) begin
        first_col = XW'(i);
      end
    end
  end

  assign pt_mask = MAX_COLUMNS'(1) << pt_x;
  assign pk_mask = MAX_COLUMNS'(1) << first_col;

  always_comb begin
    case (state)
      ST_PT_WR: new_row = fill ? (cur_row | pt_mask) : (cur_row & ~pt_mask);
      ST_DK_WR: new_row = fill ? (cur_row | disc_mask) : (cur_row & ~disc_mask);
      ST_PK_WR: new_row = cur_row & ~pk_mask;
      default:  new_row = cur_row;
    endcase
  end

  // Each row is read, then written back before the next read is issued, so a read
  // never meets a write to the same row in one cycle and no forwarding is needed.
  assign rd_en   = (state == ST_PT_RD) || (state == ST_DK_SQ) ||
                   ((state == ST_PK_SCAN) && marks[row]);
  assign wr_en   = (state == ST_PT_WR) || (state == ST_DK_WR) || (state == ST_PK_WR);
  assign wr_data = new_row;

  gpsdf_row_ram #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLUMNS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (row),
    .rd_data (rd_data)
  );

  gpsdf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sqrt_value),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Sequencer, configuration registers and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      grid_width    <= GRID_RESET;
      grid_height   <= GRID_RESET;
      marks         <= '0;
      done          <= 1'b0;
      picked_x      <= '0;
      picked_y      <= '0;
      set_was_empty <= 1'b0;
    end else begin
      done          <= 1'b0;
      picked_x      <= '0;
      picked_y      <= '0;
      set_was_empty <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            case (cmd_t'(command))
              CMD_SET_POINT, CMD_ERASE_POINT: begin
                fill <= (cmd_t'(command) == CMD_SET_POINT);
                row  <= point_y[YW-1:0];
                pt_x <= point_x[XW-1:0];
                if (in_grid) begin
                  state <= ST_PT_RD;
                end else begin
                  done <= 1'b1;
                end
              end
              CMD_FILL_DISC, CMD_CLEAR_DISC: begin
                fill <= (cmd_t'(command) == CMD_FILL_DISC);
                cx   <= point_x;
                cy   <= point_y;
                r2   <= R2_W'(radius) * R2_W'(radius);
                row  <= '0;
                if ((w_eff == '0) || (h_eff == '0)) begin
                  done <= 1'b1;
                end else begin
                  state <= ST_DK_SQ;
                end
              end
              CMD_PICK_FIRST: begin
                row   <= '0;
                state <= ST_PK_SCAN;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        ST_PT_RD: begin
          state <= ST_PT_WR;
        end

        ST_PT_WR: begin
          marks[row] <= |new_row;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end

        ST_DK_SQ: begin
          dy2   <= dy_prod[SQ_W-1:0];
          state <= ST_DK_CMP;
        end

        ST_DK_CMP: begin
          if (!band_miss) begin
            state <= ST_DK_ROOT;
          end else if (row == last_row) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            row   <= row + 1'b1;
            state <= ST_DK_SQ;
          end
        end

        ST_DK_ROOT: begin
          if (sqrt_done) begin
            lo    <= $signed({{(SPAN_W-COORD_W){cx[COORD_W-1]}}, cx}) -
                     $signed(SPAN_W'(sqrt_root));
            hi    <= $signed({{(SPAN_W-COORD_W){cx[COORD_W-1]}}, cx}) +
                     $signed(SPAN_W'(sqrt_root));
            state <= ST_DK_WR;
          end
        end

        ST_DK_WR: begin
          marks[row] <= |new_row;
          if (row == last_row) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            row   <= row + 1'b1;
            state <= ST_DK_SQ;
          end
        end

        ST_PK_SCAN: begin
          if (marks[row]) begin
            state <= ST_PK_WR;
          end else if (row == YW'(MAX_ROWS - 1)) begin
            done          <= 1'b1;
            set_was_empty <= 1'b1;
            state         <= ST_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end

        ST_PK_WR: begin
          marks[row] <= |new_row;
          picked_x   <= PICK_W'(first_col);
          picked_y   <= PICK_W'(row);
          done       <= 1'b1;
          state      <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/gpsdf_checker.sv */
`default_nettype none

module gpsdf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic [gpsdf_pkg::CMD_W-1:0]      command,
  input logic                             done,
  input logic [gpsdf_pkg::PICK_W-1:0]     picked_x,
  input logic [gpsdf_pkg::PICK_W-1:0]     picked_y,
  input logic                             set_was_empty
);
  import gpsdf_pkg::*;

  logic known_cmd;
  assign known_cmd = (command == CMD_SET_POINT) || (command == CMD_ERASE_POINT) ||
                     (command == CMD_FILL_DISC) || (command == CMD_CLEAR_DISC) ||
                     (command == CMD_PICK_FIRST);

  // a result is only shown once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an unknown command answers in the next cycle
  a_unknown_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !known_cmd) |=> (done && !busy))
    else $error("unknown command not answered at once");

  // an accepted request either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request dropped");

  // busy only rises on an accepted request
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // an empty pick carries zero coordinates and only with the strobe
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    set_was_empty |-> (done && (picked_x == '0) && (picked_y == '0)))
    else $error("empty flag with coordinates or without strobe");

endmodule

bind grid_point_set_with_disc_fill gpsdf_checker u_gpsdf_checker (.*);

`default_nettype wire
